FILE: hdl/qs_pkg.sv
// ----------------------------------------------------------------------------
// qs_pkg
// Shared widths, constants and the arctangent table for the slerp pipeline.
// ----------------------------------------------------------------------------
package qs_pkg;

  localparam int STEPS  = 30;   // cordic iterations
  localparam int DOT_W  = 34;   // four-term dot product, Q.28
  localparam int C_W    = 30;   // |dot| in Q.30
  localparam int S_W    = 31;   // sin(theta) in Q.30
  localparam int ANG_W  = 33;   // angles in Q.30
  localparam int XY_W   = 34;   // cordic x / y
  localparam int SQ_W   = 61;   // sqrt radicand
  localparam int SQ_N   = 31;   // sqrt result bits
  localparam int Q_W    = 46;   // coefficient quotient magnitude
  localparam int K_W    = 47;   // signed coefficient
  localparam int REM_W  = 31;   // divider remainder

  localparam logic [14:0]              BLEND_ONE = 15'd16384;
  localparam logic signed [XY_W-1:0]   INV_GAIN  = 34'sh26DD3B6A;
  localparam logic signed [DOT_W-1:0]  DOT_ONE   = 34'sd268435456;
  localparam logic [S_W-1:0]           S_MIN     = 31'd46340;
  localparam logic [S_W-1:0]           S_MAX     = 31'h40000000;

  typedef logic signed [15:0] comp_t;

  typedef struct packed {
    logic [3:0][15:0] src;    // w, x, y, z
    logic [3:0][15:0] dst;
    logic [14:0]      blend;  // clamped to one
    logic             neg;
    logic             big;
  } side_t;

  function automatic logic [30:0] atan_q(input int i);
    logic [30:0] v;
    case (i)
      0:  v = 31'h3243F6A8;
      1:  v = 31'h1DAC6705;
      2:  v = 31'h0FADBAFC;
      3:  v = 31'h07F56EA6;
      4:  v = 31'h03FEAB76;
      5:  v = 31'h01FFD55B;
      6:  v = 31'h00FFFAAA;
      7:  v = 31'h007FFF55;
      8:  v = 31'h003FFFEA;
      9:  v = 31'h001FFFFD;
      10: v = 31'h000FFFFF;
      11: v = 31'h0007FFFF;
      12: v = 31'h0003FFFF;
      13: v = 31'h0001FFFF;
      14: v = 31'h0000FFFF;
      15: v = 31'h00007FFF;
      16: v = 31'h00003FFF;
      17: v = 31'h00001FFF;
      18: v = 31'h00000FFF;
      19: v = 31'h000007FF;
      20: v = 31'h000003FF;
      21: v = 31'h000001FF;
      22: v = 31'h000000FF;
      23: v = 31'h0000007F;
      24: v = 31'h0000003F;
      25: v = 31'h0000001F;
      26: v = 31'h0000000F;
      27: v = 31'h00000008;
      28: v = 31'h00000004;
      29: v = 31'h00000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/qs_if.sv
// ----------------------------------------------------------------------------
// qs_if
// Valid/ready channels for quaternion pairs and interpolated quaternions.
// ----------------------------------------------------------------------------
interface qs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] src_w;
  logic signed [15:0] src_x;
  logic signed [15:0] src_y;
  logic signed [15:0] src_z;
  logic signed [15:0] dst_w;
  logic signed [15:0] dst_x;
  logic signed [15:0] dst_y;
  logic signed [15:0] dst_z;
  logic [14:0]        blend;
  modport source(output valid, src_w, src_x, src_y, src_z, dst_w, dst_x, dst_y, dst_z,
                 blend, input ready);
  modport sink(input valid, src_w, src_x, src_y, src_z, dst_w, dst_x, dst_y, dst_z,
               blend, output ready);
endinterface

interface qs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_w;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  modport source(output valid, out_w, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_w, out_x, out_y, out_z, output ready);
endinterface

FILE: hdl/qs_sqrt.sv
// ----------------------------------------------------------------------------
// qs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qs_sqrt #(
  parameter int SW = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic [qs_pkg::SQ_W-1:0]   in_v,
  input  logic [SW-1:0]             in_side,
  output logic                      out_vld,
  output logic [qs_pkg::SQ_N-1:0]   out_root,
  output logic [SW-1:0]             out_side
);

  localparam int N  = qs_pkg::SQ_N;
  localparam int RW = qs_pkg::SQ_W + 1;

  logic [N-1:0]             vld_r;
  logic [qs_pkg::SQ_W-1:0]  rem_r  [N];
  logic [RW-1:0]            root_r [N];
  logic [SW-1:0]            side_r [N];

  for (genvar j = 0; j < N; j++) begin : g_st
    localparam logic [RW-1:0] BITV = RW'(1) << (2 * (N - 1 - j));
    logic                     vin;
    logic [qs_pkg::SQ_W-1:0]  rin;
    logic [RW-1:0]            qin;
    logic [SW-1:0]            sin;
    logic [RW:0]              trial;
    logic [qs_pkg::SQ_W-1:0]  rem_nxt;
    logic [RW-1:0]            root_nxt;

    if (j == 0) begin : g_first
      assign vin = in_vld;
      assign rin = in_v;
      assign qin = '0;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld_r[j-1];
      assign rin = rem_r[j-1];
      assign qin = root_r[j-1];
      assign sin = side_r[j-1];
    end

    assign trial = {1'b0, qin} + {1'b0, BITV};

    always_comb begin
      if ({2'b00, rin} >= trial) begin
        rem_nxt  = rin - trial[qs_pkg::SQ_W-1:0];
        root_nxt = (qin >> 1) + BITV;
      end else begin
        rem_nxt  = rin;
        root_nxt = qin >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        side_r[j] <= sin;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1][N-1:0];
  assign out_side = side_r[N-1];

endmodule

FILE: hdl/qs_vec.sv
// ----------------------------------------------------------------------------
// qs_vec
// Pipelined cordic in vectoring mode: angle of (c, s), one step per stage.
// ----------------------------------------------------------------------------
module qs_vec #(
  parameter int SW = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_vld,
  input  logic [qs_pkg::C_W-1:0]           in_c,
  input  logic [qs_pkg::S_W-1:0]           in_s,
  input  logic [SW-1:0]                    in_side,
  output logic                             out_vld,
  output logic signed [qs_pkg::ANG_W-1:0]  out_th,
  output logic [SW-1:0]                    out_side
);

  localparam int N  = qs_pkg::STEPS;
  localparam int XW = qs_pkg::XY_W;
  localparam int AW = qs_pkg::ANG_W;

  logic [N-1:0]           vld_r;
  logic signed [XW-1:0]   x_r    [N];
  logic signed [XW-1:0]   y_r    [N];
  logic signed [AW-1:0]   z_r    [N];
  logic [SW-1:0]          side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic                 vin;
    logic signed [XW-1:0] xin, yin, dx, dy;
    logic signed [AW-1:0] zin, at;
    logic [SW-1:0]        sin;

    if (i == 0) begin : g_first
      assign vin = in_vld;
      assign xin = $signed({{(XW - qs_pkg::C_W){1'b0}}, in_c});
      assign yin = $signed({{(XW - qs_pkg::S_W){1'b0}}, in_s});
      assign zin = '0;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld_r[i-1];
      assign xin = x_r[i-1];
      assign yin = y_r[i-1];
      assign zin = z_r[i-1];
      assign sin = side_r[i-1];
    end

    assign dx = yin >>> i;
    assign dy = xin >>> i;
    assign at = $signed({{(AW - 31){1'b0}}, qs_pkg::atan_q(i)});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (yin > 0) begin
          x_r[i] <= xin + dx;
          y_r[i] <= yin - dy;
          z_r[i] <= zin + at;
        end else begin
          x_r[i] <= xin - dx;
          y_r[i] <= yin + dy;
          z_r[i] <= zin - at;
        end
        side_r[i] <= sin;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_th   = z_r[N-1];
  assign out_side = side_r[N-1];

endmodule

FILE: hdl/qs_rot.sv
// ----------------------------------------------------------------------------
// qs_rot
// Two-lane pipelined cordic in rotation mode, giving sin of each angle.
// ----------------------------------------------------------------------------
module qs_rot #(
  parameter int SW = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_vld,
  input  logic signed [qs_pkg::ANG_W-1:0]  in_ang [2],
  input  logic [SW-1:0]                    in_side,
  output logic                             out_vld,
  output logic signed [qs_pkg::XY_W-1:0]   out_sin [2],
  output logic [SW-1:0]                    out_side
);

  localparam int N  = qs_pkg::STEPS;
  localparam int XW = qs_pkg::XY_W;
  localparam int AW = qs_pkg::ANG_W;

  logic [N-1:0]           vld_r;
  logic signed [XW-1:0]   x_r    [N][2];
  logic signed [XW-1:0]   y_r    [N][2];
  logic signed [AW-1:0]   z_r    [N][2];
  logic [SW-1:0]          side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic          vin;
    logic [SW-1:0] sin;

    if (i == 0) begin : g_first
      assign vin = in_vld;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld_r[i-1];
      assign sin = side_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[i] <= sin;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [XW-1:0] xin, yin, dx, dy;
      logic signed [AW-1:0] zin, at;

      if (i == 0) begin : g_first
        assign xin = qs_pkg::INV_GAIN;
        assign yin = '0;
        assign zin = in_ang[l];
      end else begin : g_next
        assign xin = x_r[i-1][l];
        assign yin = y_r[i-1][l];
        assign zin = z_r[i-1][l];
      end

      assign dx = yin >>> i;
      assign dy = xin >>> i;
      assign at = $signed({{(AW - 31){1'b0}}, qs_pkg::atan_q(i)});

      always_ff @(posedge clk) begin
        if (adv) begin
          if (zin >= 0) begin
            x_r[i][l] <= xin - dx;
            y_r[i][l] <= yin + dy;
            z_r[i][l] <= zin - at;
          end else begin
            x_r[i][l] <= xin + dx;
            y_r[i][l] <= yin - dy;
            z_r[i][l] <= zin + at;
          end
        end
      end

      assign out_sin[l] = y_r[N-1][l];
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_side = side_r[N-1];

endmodule

FILE: hdl/qs_div.sv
// ----------------------------------------------------------------------------
// qs_div
// Two-lane pipelined restoring divider: k = sin * 2^30 / s, toward zero.
// ----------------------------------------------------------------------------
module qs_div #(
  parameter int SW = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_vld,
  input  logic signed [qs_pkg::XY_W-1:0]   in_num [2],
  input  logic [qs_pkg::S_W-1:0]           in_s,
  input  logic [SW-1:0]                    in_side,
  output logic                             out_vld,
  output logic signed [qs_pkg::K_W-1:0]    out_k [2],
  output logic [SW-1:0]                    out_side
);

  localparam int N  = qs_pkg::Q_W;
  localparam int RW = qs_pkg::REM_W;
  localparam int SW_ = qs_pkg::S_W;

  logic [N-1:0]             vld_r;
  logic [RW-1:0]            rem_r  [N][2];
  logic [N-1:0]             q_r    [N][2];
  logic [15:0]              mag_r  [N][2];
  logic                     neg_r  [N][2];
  logic [SW_-1:0]           s_r    [N];
  logic [SW-1:0]            side_r [N];

  logic                     ovld_r;
  logic signed [qs_pkg::K_W-1:0] k_r [2];
  logic [SW-1:0]            oside_r;

  for (genvar j = 0; j < N; j++) begin : g_st
    logic           vin;
    logic [SW_-1:0] s_in;
    logic [SW-1:0]  sin;

    if (j == 0) begin : g_first
      assign vin  = in_vld;
      assign s_in = in_s;
      assign sin  = in_side;
    end else begin : g_next
      assign vin  = vld_r[j-1];
      assign s_in = s_r[j-1];
      assign sin  = side_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_r[j]    <= s_in;
        side_r[j] <= sin;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      localparam int NB = N - 1 - j;   // numerator bit consumed here
      logic [RW-1:0]  rin;
      logic [N-1:0]   qin;
      logic [15:0]    min;
      logic           nin;
      logic           nb;
      logic [RW:0]    rs;
      logic [RW:0]    diff;
      logic           ge;

      if (j == 0) begin : g_first
        logic [qs_pkg::XY_W-1:0] mag;
        assign mag = in_num[l][qs_pkg::XY_W-1] ? -in_num[l] : in_num[l];
        assign rin = {{(RW - 16){1'b0}}, mag[31:16]};
        assign qin = '0;
        assign min = mag[15:0];
        assign nin = in_num[l][qs_pkg::XY_W-1];
      end else begin : g_next
        assign rin = rem_r[j-1][l];
        assign qin = q_r[j-1][l];
        assign min = mag_r[j-1][l];
        assign nin = neg_r[j-1][l];
      end

      if (NB >= 30) begin : g_nb
        assign nb = min[NB-30];
      end else begin : g_nz
        assign nb = 1'b0;
      end

      assign rs   = {rin, nb};
      assign diff = rs - {1'b0, s_in};
      assign ge   = rs >= {1'b0, s_in};

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j][l] <= ge ? diff[RW-1:0] : rs[RW-1:0];
          q_r[j][l]   <= qin | (N'(ge) << NB);
          mag_r[j][l] <= min;
          neg_r[j][l] <= nin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv) begin
      ovld_r <= vld_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        k_r[l] <= neg_r[N-1][l] ? -$signed({1'b0, q_r[N-1][l]})
                                : $signed({1'b0, q_r[N-1][l]});
      end
      oside_r <= side_r[N-1];
    end
  end

  assign out_vld  = ovld_r;
  assign out_k    = k_r;
  assign out_side = oside_r;

endmodule

FILE: hdl/quaternion_slerp_top.sv
// ----------------------------------------------------------------------------
// quaternion_slerp_top: fixed-point quaternion slerp pipeline
// Throughput: one word per cycle; the whole pipe advances unless the output
//   register holds a word that is not taken.
// Reset: synchronous active-low rst_n clears all valid bits; no stored state.
// ----------------------------------------------------------------------------
module quaternion_slerp_top (
  input  logic        clk,
  input  logic        rst_n,
  qs_in_if.sink       in_ch,
  qs_out_if.source    out_ch
);

  localparam int SIDE_W = $bits(qs_pkg::side_t);

  logic adv;

  // stage 1: products
  logic                 vld1_r;
  logic signed [31:0]   prod1_r [4];
  qs_pkg::side_t        side1_r;
  qs_pkg::comp_t        ia [4];
  qs_pkg::comp_t        ib [4];
  logic [14:0]          tcl;

  // stage 2: dot product
  logic                         vld2_r;
  logic [qs_pkg::C_W-1:0]       c2_r;
  qs_pkg::side_t                side2_r;
  qs_pkg::side_t                side2_nxt;
  logic signed [qs_pkg::DOT_W-1:0] dot;
  logic [qs_pkg::DOT_W-1:0]     absd;

  // stage 3: c squared
  logic                         vld3_r;
  logic [2*qs_pkg::C_W-1:0]     cc3_r;
  logic [qs_pkg::C_W-1:0]       c3_r;
  qs_pkg::side_t                side3_r;
  logic [qs_pkg::SQ_W-1:0]      rad;

  // sqrt
  logic                         sq_vld;
  logic [qs_pkg::SQ_N-1:0]      sq_root;
  logic [SIDE_W+qs_pkg::C_W-1:0] sq_side;
  qs_pkg::side_t                sq_sd;
  logic [qs_pkg::C_W-1:0]       sq_c;

  // vectoring
  logic                         vc_vld;
  logic signed [qs_pkg::ANG_W-1:0] vc_th;
  logic [SIDE_W+qs_pkg::S_W-1:0] vc_side;
  qs_pkg::side_t                vc_sd;
  logic [qs_pkg::S_W-1:0]       vc_s;

  // angle scaling
  logic                         vldm_r;
  logic signed [48:0]           m1_r, m2_r;
  logic [SIDE_W+qs_pkg::S_W-1:0] sidem_r;
  logic [14:0]                  omt;
  logic signed [qs_pkg::ANG_W-1:0] ang [2];

  // rotation
  logic                         rt_vld;
  logic signed [qs_pkg::XY_W-1:0] rt_sin [2];
  logic [SIDE_W+qs_pkg::S_W-1:0] rt_side;
  qs_pkg::side_t                rt_sd;
  logic [qs_pkg::S_W-1:0]       rt_s;

  // division
  logic                         dv_vld;
  logic signed [qs_pkg::K_W-1:0] dv_k [2];
  logic [SIDE_W-1:0]            dv_side;
  qs_pkg::side_t                dv_sd;

  // partial products
  logic                 vldp_r;
  logic signed [38:0]   ph1_r [4];
  logic signed [40:0]   pl1_r [4];
  logic signed [39:0]   ph2_r [4];
  logic signed [41:0]   pl2_r [4];
  qs_pkg::side_t        sidep_r;
  logic signed [22:0]   k1h, k2h;
  logic signed [24:0]   k1l, k2l;
  logic signed [16:0]   dd [4];

  // output register
  logic                 out_vld_r;
  qs_pkg::comp_t        res_r [4];
  qs_pkg::comp_t        res_nxt [4];

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 1
  assign ia[0] = in_ch.src_w;
  assign ia[1] = in_ch.src_x;
  assign ia[2] = in_ch.src_y;
  assign ia[3] = in_ch.src_z;
  assign ib[0] = in_ch.dst_w;
  assign ib[1] = in_ch.dst_x;
  assign ib[2] = in_ch.dst_y;
  assign ib[3] = in_ch.dst_z;
  assign tcl   = (in_ch.blend > qs_pkg::BLEND_ONE) ? qs_pkg::BLEND_ONE : in_ch.blend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vldm_r <= 1'b0;
      vldp_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_ch.valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vldm_r <= vc_vld;
      vldp_r <= dv_vld;
      out_vld_r <= vldp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        prod1_r[j]      <= ia[j] * ib[j];
        side1_r.src[j]  <= ia[j];
        side1_r.dst[j]  <= ib[j];
      end
      side1_r.blend <= tcl;
      side1_r.neg   <= 1'b0;
      side1_r.big   <= 1'b0;
    end
  end

  // ---------------- stage 2
  assign dot  = qs_pkg::DOT_W'(prod1_r[0]) + qs_pkg::DOT_W'(prod1_r[1])
              + qs_pkg::DOT_W'(prod1_r[2]) + qs_pkg::DOT_W'(prod1_r[3]);
  assign absd = dot[qs_pkg::DOT_W-1] ? -dot : dot;

  always_comb begin
    side2_nxt     = side1_r;
    side2_nxt.neg = dot < 0;
    side2_nxt.big = (dot >= qs_pkg::DOT_ONE) || (dot <= -qs_pkg::DOT_ONE);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r    <= {absd[27:0], 2'b00};
      side2_r <= side2_nxt;
    end
  end

  // ---------------- stage 3
  always_ff @(posedge clk) begin
    if (adv) begin
      cc3_r   <= c2_r * c2_r;
      c3_r    <= c2_r;
      side3_r <= side2_r;
    end
  end

  assign rad = (qs_pkg::SQ_W'(1) << 60) - {1'b0, cc3_r};

  qs_sqrt #(.SW(SIDE_W + qs_pkg::C_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vld3_r),
    .in_v     (rad),
    .in_side  ({side3_r, c3_r}),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  assign {sq_sd, sq_c} = sq_side;

  qs_vec #(.SW(SIDE_W + qs_pkg::S_W)) u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (sq_vld),
    .in_c     (sq_c),
    .in_s     (sq_root),
    .in_side  ({sq_sd, sq_root}),
    .out_vld  (vc_vld),
    .out_th   (vc_th),
    .out_side (vc_side)
  );

  assign {vc_sd, vc_s} = vc_side;
  assign omt = qs_pkg::BLEND_ONE - vc_sd.blend;

  // ---------------- angle scaling
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r    <= $signed({1'b0, omt}) * vc_th;
      m2_r    <= $signed({1'b0, vc_sd.blend}) * vc_th;
      sidem_r <= {vc_sd, vc_s};
    end
  end

  assign ang[0] = m1_r[46:14];
  assign ang[1] = m2_r[46:14];

  qs_rot #(.SW(SIDE_W + qs_pkg::S_W)) u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vldm_r),
    .in_ang   (ang),
    .in_side  (sidem_r),
    .out_vld  (rt_vld),
    .out_sin  (rt_sin),
    .out_side (rt_side)
  );

  assign {rt_sd, rt_s} = rt_side;

  qs_div #(.SW(SIDE_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (rt_vld),
    .in_num   (rt_sin),
    .in_s     (rt_s),
    .in_side  (rt_sd),
    .out_vld  (dv_vld),
    .out_k    (dv_k),
    .out_side (dv_side)
  );

  assign dv_sd = dv_side;

  // ---------------- partial products
  assign k1h = dv_k[0][46:24];
  assign k2h = dv_k[1][46:24];
  assign k1l = $signed({1'b0, dv_k[0][23:0]});
  assign k2l = $signed({1'b0, dv_k[1][23:0]});

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dd[j] = dv_sd.neg ? -$signed({dv_sd.dst[j][15], dv_sd.dst[j]})
                        : $signed({dv_sd.dst[j][15], dv_sd.dst[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        ph1_r[j] <= $signed(dv_sd.src[j]) * k1h;
        pl1_r[j] <= $signed(dv_sd.src[j]) * k1l;
        ph2_r[j] <= dd[j] * k2h;
        pl2_r[j] <= dd[j] * k2l;
      end
      sidep_r <= dv_sd;
    end
  end

  // ---------------- sum, round, saturate
  always_comb begin
    logic signed [65:0] acc;
    logic signed [65:0] sh;
    for (int j = 0; j < 4; j++) begin
      acc = (66'(ph1_r[j]) <<< 24) + 66'(pl1_r[j])
          + (66'(ph2_r[j]) <<< 24) + 66'(pl2_r[j]) + (66'sd1 <<< 29);
      sh  = acc >>> 30;
      if (sidep_r.big) begin
        res_nxt[j] = sidep_r.src[j];
      end else if (sh > 66'sd32767) begin
        res_nxt[j] = 16'sh7FFF;
      end else if (sh < -66'sd32768) begin
        res_nxt[j] = 16'sh8000;
      end else begin
        res_nxt[j] = sh[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.out_w = res_r[0];
  assign out_ch.out_x = res_r[1];
  assign out_ch.out_y = res_r[2];
  assign out_ch.out_z = res_r[3];

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_vld_r)
    else $error("output valid after reset");

  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_vld && !sq_sd.big) |-> (sq_root >= qs_pkg::S_MIN && sq_root <= qs_pkg::S_MAX))
    else $error("sin(theta) out of range");

  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rt_vld && !rt_sd.big) |->
      ((rt_sin[0][33:31] == 3'b000 || rt_sin[0][33:31] == 3'b111) &&
       (rt_sin[1][33:31] == 3'b000 || rt_sin[1][33:31] == 3'b111)))
    else $error("cordic sine exceeds divider range");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Slerp pipeline bench: drives quaternion pairs through the input channel,
// predicts each interpolated word in fixed point and checks the output
// channel in order, under random source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    qs_pkg::comp_t s[4];
    qs_pkg::comp_t d[4];
    logic [14:0]   t;
  } pair_t;

  typedef struct {
    qs_pkg::comp_t c[4];
  } quat_t;

  localparam longint ATAN_TBL[30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  logic clk;
  logic rst_n;
  qs_in_if  in_ch();
  qs_out_if out_ch();

  quaternion_slerp_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  quat_t pending_quats[$];
  int    errors;
  int    src_idle_pct;
  int    sink_stall_pct;
  int    hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("tb_top: errors");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned rem, root, b;
    rem  = v;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint vec_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic longint rot_sin(longint z);
    longint x, y, dx, dy;
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    return y;
  endfunction

  function automatic quat_t slerp_predict(pair_t p);
    quat_t  r;
    longint dot, t, c, s, th, k1, k2, dd, acc;
    dot = 0;
    for (int j = 0; j < 4; j++) dot += longint'(p.s[j]) * longint'(p.d[j]);
    t = p.t;
    if (t > 16384) t = 16384;
    if (dot >= (64'sd1 <<< 28) || dot <= -(64'sd1 <<< 28)) begin
      for (int j = 0; j < 4; j++) r.c[j] = p.s[j];
      return r;
    end
    c  = (dot < 0 ? -dot : dot) * 4;
    s  = longint'(isqrt((64'd1 << 60) - longint'(c) * longint'(c)));
    th = vec_angle(c, s);
    k1 = (rot_sin(((16384 - t) * th) >>> 14) * (64'sd1 <<< 30)) / s;
    k2 = (rot_sin((t * th) >>> 14) * (64'sd1 <<< 30)) / s;
    for (int j = 0; j < 4; j++) begin
      dd  = dot < 0 ? -longint'(p.d[j]) : longint'(p.d[j]);
      acc = (longint'(p.s[j]) * k1 + dd * k2 + (64'sd1 <<< 29)) >>> 30;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      r.c[j] = qs_pkg::comp_t'(acc);
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // sink side: random stalls, plus a counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    quat_t         want;
    qs_pkg::comp_t got[4];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_w, out_ch.out_x, out_ch.out_y, out_ch.out_z};
      if (pending_quats.size() == 0) begin
        report("unexpected word w", got[0], 0);
      end else begin
        want = pending_quats.pop_front();
        if (got[0] !== want.c[0]) report("w", got[0], want.c[0]);
        if (got[1] !== want.c[1]) report("x", got[1], want.c[1]);
        if (got[2] !== want.c[2]) report("y", got[2], want.c[2]);
        if (got[3] !== want.c[3]) report("z", got[3], want.c[3]);
      end
    end
  end

  task automatic send_pair(pair_t p);
    in_ch.valid <= 1'b1;
    in_ch.src_w <= p.s[0];
    in_ch.src_x <= p.s[1];
    in_ch.src_y <= p.s[2];
    in_ch.src_z <= p.s[3];
    in_ch.dst_w <= p.d[0];
    in_ch.dst_x <= p.d[1];
    in_ch.dst_y <= p.d[2];
    in_ch.dst_z <= p.d[3];
    in_ch.blend <= p.t;
    do @(posedge clk); while (!in_ch.ready);
    pending_quats.push_back(slerp_predict(p));
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
  endtask

  function automatic pair_t mk_pair(int sw, int sx, int sy, int sz,
                                    int dw, int dx, int dy, int dz, int t);
    pair_t p;
    p.s = '{qs_pkg::comp_t'(sw), qs_pkg::comp_t'(sx), qs_pkg::comp_t'(sy),
            qs_pkg::comp_t'(sz)};
    p.d = '{qs_pkg::comp_t'(dw), qs_pkg::comp_t'(dx), qs_pkg::comp_t'(dy),
            qs_pkg::comp_t'(dz)};
    p.t = t[14:0];
    return p;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    mode;
    mode = $urandom_range(9);
    for (int j = 0; j < 4; j++) begin
      if (mode >= 7) begin
        p.s[j] = qs_pkg::comp_t'($urandom);
        p.d[j] = qs_pkg::comp_t'($urandom);
      end else begin
        // components within +-0.5 keep the dot product at most about one
        p.s[j] = qs_pkg::comp_t'($urandom_range(16384) - 8192);
        case (mode)
          0, 1, 2: p.d[j] = qs_pkg::comp_t'($urandom_range(16384) - 8192);
          3, 4:    p.d[j] = p.s[j] + qs_pkg::comp_t'($urandom_range(128) - 64);
          default: p.d[j] = -p.s[j] + qs_pkg::comp_t'($urandom_range(128) - 64);
        endcase
      end
    end
    p.t = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(16384));
    return p;
  endfunction

  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_pair(mk_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 8192));
    send_pair(mk_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
    send_pair(mk_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 8192));
    send_pair(mk_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
    send_pair(mk_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 32767));
    send_pair(mk_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 20000));
    send_pair(mk_pair(16384, 0, 0, 0, -16384, 0, 0, 0, 4096));
    send_pair(mk_pair(11585, 11585, 0, 0, 16384, 0, 0, 0, 8192));
    send_pair(mk_pair(11585, 0, 0, 0, -16384, 0, 0, 0, 8192));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 16384));
    send_pair(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 100));
    send_pair(mk_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 9));
    send_pair(mk_pair(-32768, 0, 0, 0, 1, 0, 0, 0, 16384));
    send_pair(mk_pair(32767, 0, 0, 0, 8192, 0, 0, 0, 16384));
    send_pair(mk_pair(8192, 8192, 8192, 8192, 8192, 8192, 8192, 8191, 12000));
    send_pair(mk_pair(8192, -8192, 8192, -8192, -8192, 8192, -8192, 8191, 3000));
    send_pair(mk_pair(1, -1, 1, -1, 16383, 0, 0, 0, 1));
    drain();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (n) send_pair(rand_pair());
    drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = 500;
    repeat (200) send_pair(rand_pair());
    drain();
  endtask

  initial begin
    errors         = 0;
    hold_cycles    = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.src_w    = '0;
    in_ch.src_x    = '0;
    in_ch.src_y    = '0;
    in_ch.src_z    = '0;
    in_ch.dst_w    = '0;
    in_ch.dst_x    = '0;
    in_ch.dst_y    = '0;
    in_ch.dst_z    = '0;
    in_ch.blend    = '0;
    out_ch.ready   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(160, 0, 0);
    test_random(160, 74, 0);
    test_random(160, 0, 74);
    test_random(160, 28, 28);
    test_backpressure();
    in_ch.valid <= 1'b0;
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
